// File: hdl/lli_pkg.sv
// ============================================================================
// lli_pkg
// Shared widths, constants and transaction types for the line intersection unit.
// ============================================================================
package lli_pkg;

    localparam int COORD_W   = 32;
    localparam int D_W       = COORD_W + 1;          // dx, dy
    localparam int PROD_W    = 2 * COORD_W;          // point products
    localparam int C_W       = PROD_W + 1;           // cross term
    localparam int M_W       = 2 * D_W;              // 33x33 products
    localparam int DEN_W     = M_W + 1;              // denominator
    localparam int LO_W      = 32;                   // low chunk of the cross term
    localparam int NUM_W     = M_W + LO_W + 1;       // numerator
    localparam int Q_W       = COORD_W;              // quotient bits produced
    localparam int DIV_STEPS = Q_W;

    localparam int          APB_AW      = 3;
    localparam int          APB_DW      = 32;
    localparam logic        REG_MIN_DEN = 1'b0;      // register index (paddr[2])
    localparam logic [31:0] MIN_DEN_RST = 32'd4294967;

    localparam logic [COORD_W-1:0] SAT_POS = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic [COORD_W-1:0] SAT_NEG = {1'b1, {(COORD_W-1){1'b0}}};

    typedef struct packed {
        logic signed [COORD_W-1:0] line1_start_x;
        logic signed [COORD_W-1:0] line1_start_y;
        logic signed [COORD_W-1:0] line1_end_x;
        logic signed [COORD_W-1:0] line1_end_y;
        logic signed [COORD_W-1:0] line2_start_x;
        logic signed [COORD_W-1:0] line2_start_y;
        logic signed [COORD_W-1:0] line2_end_x;
        logic signed [COORD_W-1:0] line2_end_y;
    } t_in_item;

    typedef struct packed {
        logic                      found;
        logic signed [COORD_W-1:0] result_x;
        logic signed [COORD_W-1:0] result_y;
        logic                      saturated;
    } t_out_item;

    // front end result: denominator and numerator partial products
    typedef struct packed {
        logic signed [DEN_W-1:0] den;
        logic signed [M_W-1:0]   ax_hi;
        logic signed [M_W-1:0]   ax_lo;
        logic signed [M_W-1:0]   bx_hi;
        logic signed [M_W-1:0]   bx_lo;
        logic signed [M_W-1:0]   ay_hi;
        logic signed [M_W-1:0]   ay_lo;
        logic signed [M_W-1:0]   by_hi;
        logic signed [M_W-1:0]   by_lo;
    } t_front_item;

    typedef struct packed {
        logic [NUM_W-1:0] rem;
        logic [Q_W-1:0]   q;
        logic             neg;
        logic             ovf;
    } t_div_lane;

    typedef struct packed {
        t_div_lane        x;
        t_div_lane        y;
        logic [NUM_W-1:0] ds;     // divisor aligned to the current quotient bit
        logic             found;
    } t_div_item;

endpackage

// File: hdl/lli_front.sv
// ============================================================================
// lli_front
// Three-stage front end: deltas and point products, cross terms, denominator and numerator partials.
// ============================================================================
module lli_front
    import lli_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  t_in_item    i_data,
    output logic        o_valid,
    input  logic        i_stall,
    output t_front_item o_data
);

    logic                      r_v1, r_v2, r_v3;
    logic                      s1, s2, s3;

    logic signed [D_W-1:0]     r_dy1, r_dx1, r_dy2, r_dx2;
    logic signed [PROD_W-1:0]  r_p1a, r_p1b, r_p2a, r_p2b;

    logic signed [D_W-1:0]     r2_dy1, r2_dx1, r2_dy2, r2_dx2;
    logic signed [C_W-1:0]     r_c1, r_c2;
    logic signed [M_W-1:0]     r_m1, r_m2;

    t_front_item               r_out;

    logic signed [D_W-1:0]     n_dy1, n_dx1, n_dy2, n_dx2;
    logic signed [PROD_W-1:0]  n_p1a, n_p1b, n_p2a, n_p2b;
    logic signed [C_W-1:0]     n_c1, n_c2;
    logic signed [M_W-1:0]     n_m1, n_m2;
    t_front_item               n_out;

    assign s3      = r_v3 & i_stall;
    assign s2      = r_v2 & s3;
    assign s1      = r_v1 & s2;
    assign o_stall = s1;
    assign o_valid = r_v3;
    assign o_data  = r_out;

    always_comb begin
        n_dy1 = $signed({i_data.line1_end_y[COORD_W-1], i_data.line1_end_y})
              - $signed({i_data.line1_start_y[COORD_W-1], i_data.line1_start_y});
        n_dx1 = $signed({i_data.line1_end_x[COORD_W-1], i_data.line1_end_x})
              - $signed({i_data.line1_start_x[COORD_W-1], i_data.line1_start_x});
        n_dy2 = $signed({i_data.line2_end_y[COORD_W-1], i_data.line2_end_y})
              - $signed({i_data.line2_start_y[COORD_W-1], i_data.line2_start_y});
        n_dx2 = $signed({i_data.line2_end_x[COORD_W-1], i_data.line2_end_x})
              - $signed({i_data.line2_start_x[COORD_W-1], i_data.line2_start_x});
        n_p1a = i_data.line1_end_x * i_data.line1_start_y;
        n_p1b = i_data.line1_start_x * i_data.line1_end_y;
        n_p2a = i_data.line2_end_x * i_data.line2_start_y;
        n_p2b = i_data.line2_start_x * i_data.line2_end_y;
    end

    always_comb begin
        n_c1 = $signed({r_p1a[PROD_W-1], r_p1a}) - $signed({r_p1b[PROD_W-1], r_p1b});
        n_c2 = $signed({r_p2a[PROD_W-1], r_p2a}) - $signed({r_p2b[PROD_W-1], r_p2b});
        n_m1 = r_dy1 * r_dx2;
        n_m2 = r_dx1 * r_dy2;
    end

    // cross term split into unsigned low 32 bits and signed high part
    always_comb begin
        n_out.den   = $signed({r_m1[M_W-1], r_m1}) - $signed({r_m2[M_W-1], r_m2});
        n_out.ax_hi = r2_dx1 * $signed(r_c2[C_W-1:LO_W]);
        n_out.ax_lo = r2_dx1 * $signed({1'b0, r_c2[LO_W-1:0]});
        n_out.bx_hi = r2_dx2 * $signed(r_c1[C_W-1:LO_W]);
        n_out.bx_lo = r2_dx2 * $signed({1'b0, r_c1[LO_W-1:0]});
        n_out.ay_hi = r2_dy1 * $signed(r_c2[C_W-1:LO_W]);
        n_out.ay_lo = r2_dy1 * $signed({1'b0, r_c2[LO_W-1:0]});
        n_out.by_hi = r2_dy2 * $signed(r_c1[C_W-1:LO_W]);
        n_out.by_lo = r2_dy2 * $signed({1'b0, r_c1[LO_W-1:0]});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (!s1) r_v1 <= i_valid;
            if (!s2) r_v2 <= r_v1;
            if (!s3) r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!s1 && i_valid) begin
            r_dy1 <= n_dy1;
            r_dx1 <= n_dx1;
            r_dy2 <= n_dy2;
            r_dx2 <= n_dx2;
            r_p1a <= n_p1a;
            r_p1b <= n_p1b;
            r_p2a <= n_p2a;
            r_p2b <= n_p2b;
        end
        if (!s2 && r_v1) begin
            r2_dy1 <= r_dy1;
            r2_dx1 <= r_dx1;
            r2_dy2 <= r_dy2;
            r2_dx2 <= r_dx2;
            r_c1   <= n_c1;
            r_c2   <= n_c2;
            r_m1   <= n_m1;
            r_m2   <= n_m2;
        end
        if (!s3 && r_v2) begin
            r_out <= n_out;
        end
    end

endmodule

// File: hdl/lli_prep.sv
// ============================================================================
// lli_prep
// Numerator assembly, parallel test, magnitudes and range check for the divider.
// ============================================================================
module lli_prep
    import lli_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [APB_DW-1:0]  i_min_den,
    input  logic               i_valid,
    output logic               o_stall,
    input  t_front_item        i_data,
    output logic               o_valid,
    input  logic               i_stall,
    output t_div_item          o_data
);

    logic               r_v4, r_v5, r_v6;
    logic               s4, s5, s6;

    logic [NUM_W-1:0]   r_nx, r_ny;
    logic [DEN_W-1:0]   r_ad;
    logic               r_dneg, r_found;

    logic [NUM_W-1:0]   r_mx, r_my;
    logic [DEN_W-1:0]   r5_ad;
    logic               r_negx, r_negy, r5_found;

    t_div_item          r_out;

    logic [NUM_W-1:0]   n_nx, n_ny;
    logic [DEN_W-1:0]   n_ad;
    logic               n_found;
    logic [NUM_W-1:0]   n_mx, n_my;
    logic [NUM_W-1:0]   w_dfull;
    t_div_item          n_out;

    assign s6      = r_v6 & i_stall;
    assign s5      = r_v5 & s6;
    assign s4      = r_v4 & s5;
    assign o_stall = s4;
    assign o_valid = r_v6;
    assign o_data  = r_out;

    always_comb begin
        n_nx = {i_data.ax_hi[M_W-1], i_data.ax_hi, {LO_W{1'b0}}}
             + {{(NUM_W-M_W){i_data.ax_lo[M_W-1]}}, i_data.ax_lo}
             - {i_data.bx_hi[M_W-1], i_data.bx_hi, {LO_W{1'b0}}}
             - {{(NUM_W-M_W){i_data.bx_lo[M_W-1]}}, i_data.bx_lo};
        n_ny = {i_data.ay_hi[M_W-1], i_data.ay_hi, {LO_W{1'b0}}}
             + {{(NUM_W-M_W){i_data.ay_lo[M_W-1]}}, i_data.ay_lo}
             - {i_data.by_hi[M_W-1], i_data.by_hi, {LO_W{1'b0}}}
             - {{(NUM_W-M_W){i_data.by_lo[M_W-1]}}, i_data.by_lo};
        n_ad = i_data.den[DEN_W-1] ? (~i_data.den + 1'b1) : i_data.den;
        // exact zero counts as parallel even with a zero threshold
        n_found = (n_ad != '0) && (n_ad >= {{(DEN_W-APB_DW){1'b0}}, i_min_den});
    end

    always_comb begin
        n_mx = r_nx[NUM_W-1] ? (~r_nx + 1'b1) : r_nx;
        n_my = r_ny[NUM_W-1] ? (~r_ny + 1'b1) : r_ny;
    end

    always_comb begin
        w_dfull     = {r5_ad, {LO_W{1'b0}}};
        n_out.x.rem = r_mx;
        n_out.x.q   = '0;
        n_out.x.neg = r_negx;
        n_out.x.ovf = (r_mx >= w_dfull);
        n_out.y.rem = r_my;
        n_out.y.q   = '0;
        n_out.y.neg = r_negy;
        n_out.y.ovf = (r_my >= w_dfull);
        n_out.ds    = {1'b0, r5_ad, {(Q_W-1){1'b0}}};
        n_out.found = r5_found;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
        end else begin
            if (!s4) r_v4 <= i_valid;
            if (!s5) r_v5 <= r_v4;
            if (!s6) r_v6 <= r_v5;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!s4 && i_valid) begin
            r_nx    <= n_nx;
            r_ny    <= n_ny;
            r_ad    <= n_ad;
            r_dneg  <= i_data.den[DEN_W-1];
            r_found <= n_found;
        end
        if (!s5 && r_v4) begin
            r_mx     <= n_mx;
            r_my     <= n_my;
            r5_ad    <= r_ad;
            r_negx   <= r_nx[NUM_W-1] ^ r_dneg;
            r_negy   <= r_ny[NUM_W-1] ^ r_dneg;
            r5_found <= r_found;
        end
        if (!s6 && r_v5) begin
            r_out <= n_out;
        end
    end

endmodule

// File: hdl/lli_div_cell.sv
// ============================================================================
// lli_div_cell
// One restoring-division step for both coordinates; yields one quotient bit.
// ============================================================================
module lli_div_cell
    import lli_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  t_div_item  i_data,
    output logic       o_valid,
    input  logic       i_stall,
    output t_div_item  o_data
);

    logic      r_valid;
    t_div_item r_data;
    t_div_item n_data;
    logic      w_gex, w_gey;

    assign o_stall = r_valid & i_stall;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_comb begin
        n_data   = i_data;
        w_gex    = (i_data.x.rem >= i_data.ds);
        w_gey    = (i_data.y.rem >= i_data.ds);
        if (w_gex) begin
            n_data.x.rem = i_data.x.rem - i_data.ds;
        end
        if (w_gey) begin
            n_data.y.rem = i_data.y.rem - i_data.ds;
        end
        n_data.x.q = {i_data.x.q[Q_W-2:0], w_gex};
        n_data.y.q = {i_data.y.q[Q_W-2:0], w_gey};
        n_data.ds  = i_data.ds >> 1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_data <= n_data;
        end
    end

endmodule

// File: hdl/line_line_intersection_unit.sv
// ============================================================================
// line_line_intersection_unit
// Intersection of two 2-D lines in Q16.16 with parallel test and saturation.
// ============================================================================
// Pipeline: 3 front stages, 3 prep stages, 32 divider cells, 1 output register.
// Throughput: one transaction per cycle while the output is not stalled; each cell
// stage stalls only when full and its successor stalls, so bubbles collapse.
// Reset (synchronous, active low) empties the pipeline and loads
// min_denominator with 4294967.
module line_line_intersection_unit
    import lli_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_in_item          i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_out_item         o_out_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    logic [APB_DW-1:0] r_min_den;

    logic              w_front_valid, w_front_stall;
    t_front_item       w_front_data;
    logic              w_prep_stall;

    logic              w_cv [DIV_STEPS+1];
    logic              w_cs [DIV_STEPS+1];
    t_div_item         w_cd [DIV_STEPS+1];

    logic              r_out_valid;
    t_out_item         r_out;
    t_out_item         n_out;
    t_div_item         w_fin;
    logic              w_out_stall;
    logic              w_satx, w_saty;
    logic [Q_W-1:0]    w_limx, w_limy;

    // ---------------- configuration ----------------
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_MIN_DEN) ? r_min_den : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_den <= MIN_DEN_RST;
        end else if (psel && penable && pwrite && paddr[2] == REG_MIN_DEN) begin
            r_min_den <= pwdata;
        end
    end

    // ---------------- pipeline ----------------
    lli_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_stall (o_in_stall),
        .i_data  (i_in_data),
        .o_valid (w_front_valid),
        .i_stall (w_front_stall),
        .o_data  (w_front_data)
    );

    assign w_front_stall = w_prep_stall;

    lli_prep u_prep (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_min_den (r_min_den),
        .i_valid   (w_front_valid),
        .o_stall   (w_prep_stall),
        .i_data    (w_front_data),
        .o_valid   (w_cv[0]),
        .i_stall   (w_cs[0]),
        .o_data    (w_cd[0])
    );

    for (genvar g = 0; g < DIV_STEPS; g++) begin : g_cell
        lli_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_cv[g]),
            .o_stall (w_cs[g]),
            .i_data  (w_cd[g]),
            .o_valid (w_cv[g+1]),
            .i_stall (w_cs[g+1]),
            .o_data  (w_cd[g+1])
        );
    end

    // ---------------- saturation and output register ----------------
    assign w_out_stall     = r_out_valid & i_out_stall;
    assign w_cs[DIV_STEPS] = w_out_stall;
    assign w_fin           = w_cd[DIV_STEPS];

    always_comb begin
        w_limx = w_fin.x.neg ? SAT_NEG : SAT_POS;
        w_limy = w_fin.y.neg ? SAT_NEG : SAT_POS;
        w_satx = w_fin.x.ovf || (w_fin.x.q > w_limx);
        w_saty = w_fin.y.ovf || (w_fin.y.q > w_limy);
        if (w_fin.found) begin
            n_out.found     = 1'b1;
            n_out.result_x  = w_satx ? w_limx : (w_fin.x.neg ? (~w_fin.x.q + 1'b1) : w_fin.x.q);
            n_out.result_y  = w_saty ? w_limy : (w_fin.y.neg ? (~w_fin.y.q + 1'b1) : w_fin.y.q);
            n_out.saturated = w_satx | w_saty;
        end else begin
            n_out = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!w_out_stall) begin
            r_out_valid <= w_cv[DIV_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!w_out_stall && w_cv[DIV_STEPS]) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// File: hdl/lli_checker.sv
// ============================================================================
// lli_checker
// Port-level checks on the line intersection unit, bound to the top level.
// ============================================================================
module lli_checker
    import lli_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_in_stall,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out_data
);

    // input backpressure only ever comes from a blocked result
    a_stall_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled while output not blocked");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled result changed");

    a_parallel_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.found) |->
            (o_out_data.result_x == '0 && o_out_data.result_y == '0
             && !o_out_data.saturated))
        else $error("parallel result not zeroed");

    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("result valid right after reset");

endmodule

bind line_line_intersection_unit lli_checker u_lli_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

// File: tb/tb_top.sv
// ============================================================================
// tb_top
// Self-checking bench for the line intersection unit: a bit-exact predictor of
// the parallel test, division and saturation is compared against every result
// under random sender gaps, receiver stalls and several threshold settings.
// ============================================================================
module tb_top;
    import lli_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY = 39;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_stall;
    t_in_item          i_in_data;
    logic              o_out_valid;
    logic              i_out_stall;
    t_out_item         o_out_data;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    line_line_intersection_unit dut (.*);

    t_out_item    expected_points[$];
    logic [31:0]  min_den;
    int           n_mismatch;
    int           n_checked;
    int           n_parallel;
    int           n_saturated;
    int           n_sent;
    int           burst_left;
    int           stall_mode;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("line_line_intersection_unit test failed");
        $finish;
    end

    // Quotient truncated toward zero and clamped to 32 bits.
    function automatic logic signed [31:0] clamp_div(logic signed [159:0] num,
                                                     logic signed [159:0] den,
                                                     ref logic sat);
        logic signed [159:0] q;
        q = num / den;
        if (q > 160'sd2147483647) begin
            sat = 1'b1;
            return SAT_POS;
        end
        if (q < -160'sd2147483648) begin
            sat = 1'b1;
            return SAT_NEG;
        end
        return q[31:0];
    endfunction

    function automatic t_out_item predict_point(t_in_item a);
        logic signed [159:0] sx1, sy1, ex1, ey1, sx2, sy2, ex2, ey2;
        logic signed [159:0] dx1, dy1, dx2, dy2, c1, c2, den, aden;
        t_out_item r;
        logic sat;
        sx1 = a.line1_start_x; sy1 = a.line1_start_y;
        ex1 = a.line1_end_x;   ey1 = a.line1_end_y;
        sx2 = a.line2_start_x; sy2 = a.line2_start_y;
        ex2 = a.line2_end_x;   ey2 = a.line2_end_y;
        dx1 = ex1 - sx1; dy1 = ey1 - sy1;
        dx2 = ex2 - sx2; dy2 = ey2 - sy2;
        c1 = ex1 * sy1 - sx1 * ey1;
        c2 = ex2 * sy2 - sx2 * ey2;
        den = dy1 * dx2 - dx1 * dy2;
        aden = den < 0 ? -den : den;
        r = '0;
        if (aden == 0 || aden < $signed({128'd0, min_den}))
            return r;
        sat = 1'b0;
        r.found = 1'b1;
        r.result_x = clamp_div(dx1 * c2 - dx2 * c1, den, sat);
        r.result_y = clamp_div(dy1 * c2 - dy2 * c1, den, sat);
        r.saturated = sat;
        return r;
    endfunction

    // receiver stall pattern
    always @(negedge i_clk) begin
        case (stall_mode)
            0: i_out_stall <= 1'b0;
            1: i_out_stall <= ($urandom_range(0, 3) == 0);
            default: i_out_stall <= ($urandom_range(0, 9) < 7);
        endcase
    end

    always @(posedge i_clk) begin
        t_out_item e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_points.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10)
                    $display("unexpected result transaction %p", o_out_data);
            end else begin
                e = expected_points.pop_front();
                n_checked++;
                if (!e.found) n_parallel++;
                if (e.saturated) n_saturated++;
                if (o_out_data !== e) begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("mismatch: expected %p, got %p", e, o_out_data);
                end
            end
        end
    end

    task automatic apb_write(logic [31:0] v);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= {REG_MIN_DEN, 2'b00}; pwdata <= v;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        min_den = v;
    endtask

    task automatic drain();
        while (expected_points.size() != 0) @(negedge i_clk);
        repeat (LATENCY + 5) @(negedge i_clk);
    endtask

    task automatic send_line_pair(t_in_item a);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 4);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        i_in_valid <= 1'b1;
        i_in_data <= a;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        expected_points.push_back(predict_point(a));
        n_sent++;
        burst_left--;
        @(negedge i_clk);
    endtask

    task automatic idle_input();
        i_in_valid <= 1'b0;
        burst_left = 0;
        @(negedge i_clk);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
            2: return $signed($urandom_range(0, 400)) - 200;
            default: return ($signed($urandom_range(0, 2000)) - 1000) <<< 16;
        endcase
    endfunction

    function automatic t_in_item rand_pair();
        t_in_item a;
        a = {rand_coord(), rand_coord(), rand_coord(), rand_coord(),
             rand_coord(), rand_coord(), rand_coord(), rand_coord()};
        // sometimes make the second line parallel or nearly so
        if ($urandom_range(0, 7) == 0) begin
            a.line2_end_x = a.line2_start_x + (a.line1_end_x - a.line1_start_x);
            a.line2_end_y = a.line2_start_y + (a.line1_end_y - a.line1_start_y)
                            + $signed($urandom_range(0, 2)) - 1;
        end
        return a;
    endfunction

    task automatic test_directed();
        t_in_item a;
        stall_mode = 0;
        // crossing axes at the origin
        send_line_pair('{-65536, 0, 65536, 0, 0, -65536, 0, 65536});
        // crossing at (1,2)
        send_line_pair('{0, 131072, 131072, 131072, 65536, 0, 65536, 262144});
        // exactly parallel
        send_line_pair('{0, 0, 65536, 65536, 0, 65536, 65536, 131072});
        // identical lines and degenerate points
        send_line_pair('{0, 0, 65536, 65536, 0, 0, 65536, 65536});
        send_line_pair('0);
        // tiny slope gap: denominator of one ulp, below default threshold
        send_line_pair('{0, 0, 1, 0, 0, 0, 1, 1});
        // near parallel with far crossing: saturation
        send_line_pair('{0, 0, 32'h7fff0000, 0, 0, 65536, 32'h7fff0000, 65537});
        send_line_pair('{0, 0, -65536, 0, 32'h80000000, 65536, 32'h7fffffff, 65535});
        // field extremes
        a = {8{32'h7fffffff}};
        send_line_pair(a);
        send_line_pair('{32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
                         32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000});
        send_line_pair('{32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff,
                         32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff});
        send_line_pair('{-1, -1, 1, 1, -1, 1, 1, -1});
        send_line_pair({8{32'hffffffff}});
        idle_input();
    endtask

    task automatic test_threshold(logic [31:0] th, int n);
        drain();
        apb_write(th);
        if (th == 0) begin
            send_line_pair('{0, 0, 65536, 65536, 0, 65536, 65536, 131072});
            send_line_pair('{0, 0, 1, 0, 0, 0, 1, 1});
        end
        repeat (n) send_line_pair(rand_pair());
        idle_input();
    endtask

    task automatic test_random_stream(int n);
        for (int i = 0; i < n; i++) begin
            if (i % 200 == 0) stall_mode = $urandom_range(0, 2);
            send_line_pair(rand_pair());
        end
        idle_input();
    endtask

    initial begin
        i_rst_n = 1'b0; i_in_valid = 1'b0; i_in_data = '0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        min_den = MIN_DEN_RST;
        n_mismatch = 0; n_checked = 0; n_parallel = 0; n_saturated = 0;
        n_sent = 0; burst_left = 0; stall_mode = 0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed();
        stall_mode = 1;
        test_random_stream(900);
        stall_mode = 2;
        test_threshold(32'd0, 150);
        test_threshold(32'hffffffff, 150);
        test_threshold(32'd1 << 20, 150);
        stall_mode = 1;
        test_threshold(MIN_DEN_RST, 250);
        drain();

        $display("covered %0d transactions: %0d parallel, %0d saturated, 4 thresholds",
                 n_checked, n_parallel, n_saturated);
        if (n_mismatch == 0 && expected_points.size() == 0)
            $display("line_line_intersection_unit test passed");
        else
            $display("line_line_intersection_unit test failed");
        $finish;
    end
endmodule

// File: files.f
hdl/lli_pkg.sv
hdl/lli_front.sv
hdl/lli_prep.sv
hdl/lli_div_cell.sv
hdl/line_line_intersection_unit.sv
hdl/lli_checker.sv
tb/tb_top.sv
